// ===== src/idempotency_key_table_unit_macros.svh =====
// Assertion macros used by the block's checker.
`ifndef IDEMPOTENCY_KEY_TABLE_UNIT_MACROS_SVH
`define IDEMPOTENCY_KEY_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define IKT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("idempotency key table check failed");

// Next-cycle implication, disabled while reset is low.
`define IKT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("idempotency key table check failed");

`endif

// ===== src/ikt_pkg.sv =====
// Types and constants of the idempotency key table.
`default_nettype none
package ikt_pkg;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_BYTES   = 32;
    localparam int KEY_BITS    = 256;
    localparam int MIN_KEY_LEN = 8;
    localparam int PADDR_W     = 3;
    localparam logic [31:0] RETENTION_RESET = 32'd600000;

    localparam logic [1:0] MODE_LOOKUP   = 2'd0;
    localparam logic [1:0] MODE_REMEMBER = 2'd1;
    localparam logic [1:0] MODE_CLEAR    = 2'd2;

    localparam logic [2:0] STATUS_INVALID   = 3'd0;
    localparam logic [2:0] STATUS_NEW       = 3'd1;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd2;
    localparam logic [2:0] STATUS_CONFLICT  = 3'd3;
    localparam logic [2:0] STATUS_STORED    = 3'd4;
    localparam logic [2:0] STATUS_CLEARED   = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [5:0]  key_length;
        logic [31:0] request_fingerprint;
        logic [31:0] now_ms;
        logic [63:0] payload_in;
    } ikt_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] payload_out;
    } ikt_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } ikt_state_t;
endpackage
`default_nettype wire

// ===== src/idempotency_key_table_unit.sv =====
// Idempotency key table top level: sequencer, slot scan unit and config port.
// Throughput: one item at a time; the slot scan reads one slot per cycle from the RAM.
// s_ready is high only while idle; a finished result waits in the output register.
// Reset (synchronous, aresetn low): table empty, retention 600000 ms, no result pending.
// No clearing pass: per-slot used flags are cleared at once by reset or clear.
`default_nettype none
module idempotency_key_table_unit
    import ikt_pkg::*;
#(
    parameter int CAPACITY     = 16,
    parameter int ID_BYTES     = 32,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ikt_in_t            s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ikt_out_t                m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int REC_W = KEY_BITS + 64 + PAYLOAD_BITS;

    ikt_state_t state_reg, state_next;

    // Control state
    logic [CAPACITY-1:0] used_reg;
    logic [31:0]         retention_reg;
    logic                m_valid_reg;
    logic                ev_valid_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;

    // Working registers of the current item
    ikt_in_t             item_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [IDX_W-1:0]    ev_idx_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                have_old_reg;
    logic [IDX_W-1:0]    old_idx_reg;
    logic [31:0]         oldest_reg;
    logic [2:0]          status_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    ikt_out_t            out_reg;

    logic [KEY_BITS-1:0] key_masked;
    logic                key_valid;
    logic                in_fire, out_free, rd_en, wr_en, scan_end;
    logic [IDX_W-1:0]    wr_idx;
    logic [REC_W-1:0]    wr_rec, rd_rec;

    // Slot scan unit signals
    logic [KEY_BITS-1:0]     slot_key;
    logic [31:0]             slot_fp, slot_time, slot_age;
    logic [PAYLOAD_BITS-1:0] slot_pay;
    logic                    slot_expired, slot_live, slot_match;

    ikt_key_check #(.ID_BYTES(ID_BYTES)) u_key_check (
        .key_raw    ({item_reg.key_word3, item_reg.key_word2,
                      item_reg.key_word1, item_reg.key_word0}),
        .key_length (item_reg.key_length),
        .key_masked (key_masked),
        .key_valid  (key_valid)
    );

    ikt_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_rec)
    );

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign scan_end = (rd_cnt_reg == CNT_W'(CAPACITY)) && !ev_valid_reg;
    assign wr_idx   = found_reg ? hit_idx_reg : old_idx_reg;
    assign wr_rec   = {key_reg, item_reg.request_fingerprint, item_reg.now_ms,
                       item_reg.payload_in[PAYLOAD_BITS-1:0]};

    // Evaluate the slot whose record just came out of the RAM.
    assign slot_key     = rd_rec[REC_W-1 -: KEY_BITS];
    assign slot_fp      = rd_rec[PAYLOAD_BITS+63 -: 32];
    assign slot_time    = rd_rec[PAYLOAD_BITS+31 -: 32];
    assign slot_pay     = rd_rec[PAYLOAD_BITS-1:0];
    assign slot_age     = item_reg.now_ms - slot_time;
    assign slot_expired = used_reg[ev_idx_reg] && (slot_age >= retention_reg);
    assign slot_live    = used_reg[ev_idx_reg] && !slot_expired;
    assign slot_match   = slot_live && (slot_key == key_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (item_reg.mode == MODE_LOOKUP || item_reg.mode == MODE_REMEMBER) begin
                    state_next = key_valid ? ST_SCAN : ST_DONE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = (item_reg.mode == MODE_REMEMBER) ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_SCAN:  rd_en   = rd_cnt_reg < CNT_W'(CAPACITY);
            ST_WRITE: wr_en   = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            retention_reg <= RETENTION_RESET;
            m_valid_reg   <= 1'b0;
            ev_valid_reg  <= 1'b0;
            rd_cnt_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            ev_valid_reg <= rd_en;
            if (psel && penable && pwrite && !paddr[2]) begin
                retention_reg <= pwdata;
            end
            // Load a new result, else drop the one just taken.
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_CHECK) begin
                rd_cnt_reg <= '0;
                if (item_reg.mode == MODE_CLEAR) used_reg <= '0;
            end
            if (rd_en) rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            // Drop expired slots as the scan passes them.
            if (ev_valid_reg && slot_expired) used_reg[ev_idx_reg] <= 1'b0;
            if (wr_en) used_reg[wr_idx] <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire) item_reg <= s_data;
        ev_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        if (state_reg == ST_CHECK) begin
            key_reg      <= key_masked;
            found_reg    <= 1'b0;
            have_old_reg <= 1'b0;
            pay_reg      <= '0;
            if (item_reg.mode == MODE_CLEAR) begin
                status_reg <= STATUS_CLEARED;
            end else if (item_reg.mode == MODE_LOOKUP && key_valid) begin
                status_reg <= STATUS_NEW;
            end else if (item_reg.mode == MODE_REMEMBER && key_valid) begin
                status_reg <= STATUS_STORED;
            end else begin
                status_reg <= STATUS_INVALID;
            end
        end
        if (state_reg == ST_SCAN && ev_valid_reg && !found_reg) begin
            if (item_reg.mode == MODE_LOOKUP) begin
                if (slot_match) begin
                    found_reg <= 1'b1;
                    if (slot_fp == item_reg.request_fingerprint) begin
                        status_reg <= STATUS_DUPLICATE;
                        pay_reg    <= slot_pay;
                    end else begin
                        status_reg <= STATUS_CONFLICT;
                    end
                end
            end else if (!slot_live || slot_match) begin
                // First free or same-key slot wins.
                found_reg   <= 1'b1;
                hit_idx_reg <= ev_idx_reg;
            end else if (!have_old_reg || slot_age > oldest_reg) begin
                have_old_reg <= 1'b1;
                old_idx_reg  <= ev_idx_reg;
                oldest_reg   <= slot_age;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            out_reg.status      <= status_reg;
            out_reg.payload_out <= 64'(pay_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign pready  = 1'b1;
    assign prdata  = paddr[2] ? 32'd0 : retention_reg;
endmodule
`default_nettype wire

// ===== src/ikt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ikt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== src/ikt_key_check.sv =====
// Key masking to its length and character validation.
`default_nettype none
module ikt_key_check
    import ikt_pkg::*;
#(
    parameter int ID_BYTES = 32
) (
    input  wire logic [KEY_BITS-1:0] key_raw,
    input  wire logic [5:0]          key_length,
    output logic      [KEY_BITS-1:0] key_masked,
    output logic                     key_valid
);
    logic [KEY_BYTES-1:0] byte_ok;

    always_comb begin
        logic [7:0] c;
        logic       keep;
        for (int i = 0; i < KEY_BYTES; i++) begin
            keep = 6'(i) < key_length;
            c = key_raw[8*i +: 8];
            key_masked[8*i +: 8] = keep ? c : 8'd0;
            byte_ok[i] = !keep ||
                (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                (c >= "a" && c <= "z") || c == "-" || c == "_" || c == ".";
        end
        key_valid = (key_length >= 6'(MIN_KEY_LEN)) && (key_length < 6'(ID_BYTES))
                    && (&byte_ok);
    end
endmodule
`default_nettype wire

// ===== src/ikt_checker.sv =====
// Port-level checker for the idempotency key table and its bind.
`default_nettype none
`include "idempotency_key_table_unit_macros.svh"
module ikt_checker
    import ikt_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire ikt_out_t m_data
);
    `IKT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `IKT_ASSERT_NOW(a_pay_dup_only, aclk, aresetn, m_valid && m_data.payload_out != 64'd0, m_data.status == STATUS_DUPLICATE)
    `IKT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `IKT_ASSERT_NOW(a_status_range, aclk, aresetn, m_valid, m_data.status <= STATUS_CLEARED)
endmodule

bind idempotency_key_table_unit ikt_checker u_ikt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
